>>> rtl/cth_pkg.sv
// shared constants, types and helpers for the chained token block hash
package cth_pkg;

  localparam int unsigned TOKEN_W = 32;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned WORD_W  = 64;

  localparam logic [WORD_W-1:0] GOLDEN_MUL = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] FIN_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] FIN_MUL_B  = 64'h94d049bb133111eb;

  localparam int unsigned SH_FIN_1 = 30;
  localparam int unsigned SH_FIN_2 = 27;
  localparam int unsigned SH_FIN_3 = 31;
  localparam int unsigned SH_MIX   = 29;

  // which multiplier constant the shared unit applies
  typedef enum logic [1:0] {
    K_GOLD,
    K_FIN_A,
    K_FIN_B
  } mul_k_t;

  function automatic logic [WORD_W-1:0] mul_const(input mul_k_t k);
    logic [WORD_W-1:0] c;
    unique case (k)
      K_GOLD:  c = GOLDEN_MUL;
      K_FIN_A: c = FIN_MUL_A;
      K_FIN_B: c = FIN_MUL_B;
      default: c = GOLDEN_MUL;
    endcase
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] xsh(input logic [WORD_W-1:0] v,
                                            input int unsigned sh);
    return v ^ (v >> sh);
  endfunction

endpackage

>>> rtl/cth_cfg_if.sv
// configuration write channel carrying the root seed
interface cth_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cth_pkg::WORD_W-1:0] root_seed;

  modport source(output valid, root_seed, input ready);
  modport sink(input valid, root_seed, output ready);
endinterface

>>> rtl/cth_in_if.sv
// token request channel
interface cth_in_if;
  logic                        valid;
  logic                        ready;
  logic [cth_pkg::TOKEN_W-1:0] token;
  logic [cth_pkg::WORD_W-1:0]  extra;
  logic                        restart;

  modport source(output valid, token, extra, restart, input ready);
  modport sink(input valid, token, extra, restart, output ready);
endinterface

>>> rtl/cth_out_if.sv
// block hash result channel
interface cth_out_if;
  logic                       valid;
  logic                       ready;
  logic [cth_pkg::WORD_W-1:0] digest;

  modport source(output valid, digest, input ready);
  modport sink(input valid, digest, output ready);
endinterface

>>> rtl/cth_mul64.sv
// iterative 64x64 low-half multiplier built on one 32x32 multiplier
module cth_mul64 (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cth_pkg::WORD_W-1:0] a,
  input  cth_pkg::mul_k_t            k,
  output logic                       done,
  output logic [cth_pkg::WORD_W-1:0] prod
);

  localparam int unsigned HW = cth_pkg::HALF_W;
  localparam int unsigned WW = cth_pkg::WORD_W;

  logic [WW-1:0] b;
  logic [HW-1:0] x, y;
  logic [WW-1:0] pp;
  logic [1:0]    ph_r;
  logic          busy_r;
  logic          done_r;
  logic [WW-1:0] pp_r;
  logic [WW-1:0] acc_r;

  assign b = cth_pkg::mul_const(k);

  // partial products: lo*lo, then the two cross terms (only their low halves matter)
  always_comb begin
    unique case (ph_r)
      2'd0: begin
        x = a[HW-1:0];
        y = b[HW-1:0];
      end
      2'd1: begin
        x = a[HW-1:0];
        y = b[WW-1:HW];
      end
      default: begin
        x = a[WW-1:HW];
        y = b[HW-1:0];
      end
    endcase
  end

  assign pp = WW'(x) * WW'(y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 2'd0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (ph_r == 2'd3) begin
          busy_r <= 1'b0;
          ph_r   <= 2'd0;
          done_r <= 1'b1;
        end else begin
          ph_r <= ph_r + 2'd1;
        end
      end else if (start) begin
        busy_r <= 1'b1;
        ph_r   <= 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pp_r <= pp;
    if (busy_r) begin
      if (ph_r == 2'd1) begin
        acc_r <= pp_r;
      end else begin
        acc_r[WW-1:HW] <= acc_r[WW-1:HW] + pp_r[HW-1:0];
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("multiplier started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("multiplier done held longer than one cycle");

endmodule

>>> rtl/chained_token_block_hash_core.sv
// Chained token block hash: tokens are grouped into blocks of TOKENS_PER_BLK and each
// completed block emits one 64-bit hash that also seeds the next block. All 64-bit
// multiplies go through one shared unit that forms the low product from three 32x32
// partial products, and the block takes no request while a multiply runs. A token
// that only gets held as the low half of a pair needs no multiply; a token that
// completes a pair needs one. The first token of a block adds the three seeding
// multiplies, and the last token adds the length absorb and two finalizer multiplies
// plus the ST_EMIT state that loads the result register (one more multiply when the
// block has an odd token count). A finished hash waits in the output register while
// the next block's tokens are already being taken.
module chained_token_block_hash_core #(
  parameter int unsigned TOKENS_PER_BLK = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  cth_cfg_if.sink          cfg_ch,
  cth_in_if.sink           in_ch,
  cth_out_if.source        out_ch
);

  localparam int unsigned WW   = cth_pkg::WORD_W;
  localparam int unsigned TW   = cth_pkg::TOKEN_W;
  localparam int unsigned CntW = $clog2(TOKENS_PER_BLK + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(TOKENS_PER_BLK);
  localparam logic [WW-1:0]   LenWord = WW'(TOKENS_PER_BLK);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_A,
    ST_SEED_B,
    ST_SEED_G,
    ST_PAIR_G,
    ST_TAIL_G,
    ST_LEN_G,
    ST_FIN_A,
    ST_FIN_B,
    ST_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [WW-1:0]       root_r, root_nxt;
  logic                at_root_r, at_root_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                hold_r, hold_nxt;
  logic                mul_start_r, mul_start_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WW-1:0]       out_hash_r, out_hash_nxt;
  logic [WW-1:0]       acc_r, acc_nxt;
  logic [WW-1:0]       parent_r, parent_nxt;
  logic [TW-1:0]       held_r, held_nxt;
  logic [TW-1:0]       tok_r, tok_nxt;
  logic [WW-1:0]       extra_r, extra_nxt;
  logic [WW-1:0]       mul_a_r, mul_a_nxt;
  cth_pkg::mul_k_t     mul_k_r, mul_k_nxt;

  logic                mul_done;
  logic [WW-1:0]       mul_prod;
  logic [WW-1:0]       mix_p;
  logic [WW-1:0]       parent_sel;
  logic [CntW-1:0]     cnt_inc;
  logic                in_fire;
  logic                first_tok;

  cth_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .k     (mul_k_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign cfg_ch.ready  = 1'b1;
  assign in_ch.ready   = (state_r == ST_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.digest = out_hash_r;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign mix_p      = cth_pkg::xsh(mul_prod, cth_pkg::SH_MIX);
  assign cnt_inc    = cnt_r + CntW'(1);
  // restart drops the partial block and reseeds from the root
  assign first_tok  = in_ch.restart || (cnt_r == '0);
  assign parent_sel = (in_ch.restart || at_root_r) ? root_r : parent_r;

  always_comb begin
    state_nxt     = state_r;
    root_nxt      = cfg_ch.valid ? cfg_ch.root_seed : root_r;
    at_root_nxt   = at_root_r;
    cnt_nxt       = cnt_r;
    hold_nxt      = hold_r;
    mul_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hash_nxt  = out_hash_r;
    acc_nxt       = acc_r;
    parent_nxt    = parent_r;
    held_nxt      = held_r;
    tok_nxt       = tok_r;
    extra_nxt     = extra_r;
    mul_a_nxt     = mul_a_r;
    mul_k_nxt     = mul_k_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          tok_nxt   = in_ch.token;
          extra_nxt = in_ch.extra;
          if (first_tok) begin
            at_root_nxt   = in_ch.restart || at_root_r;
            cnt_nxt       = '0;
            hold_nxt      = 1'b0;
            mul_a_nxt     = cth_pkg::xsh(parent_sel, cth_pkg::SH_FIN_1);
            mul_k_nxt     = cth_pkg::K_FIN_A;
            mul_start_nxt = 1'b1;
            state_nxt     = ST_SEED_A;
          end else if (hold_r) begin
            cnt_nxt       = cnt_inc;
            hold_nxt      = 1'b0;
            mul_a_nxt     = acc_r ^ {in_ch.token, held_r};
            mul_k_nxt     = cth_pkg::K_GOLD;
            mul_start_nxt = 1'b1;
            state_nxt     = ST_PAIR_G;
          end else begin
            cnt_nxt  = cnt_inc;
            hold_nxt = 1'b1;
            held_nxt = in_ch.token;
            if (cnt_inc == CntLast) begin
              // odd block: lone last token absorbed zero-extended
              mul_a_nxt     = acc_r ^ {{(WW-TW){1'b0}}, in_ch.token};
              mul_k_nxt     = cth_pkg::K_GOLD;
              mul_start_nxt = 1'b1;
              state_nxt     = ST_TAIL_G;
            end
          end
        end
      end
      ST_SEED_A: begin
        if (mul_done) begin
          mul_a_nxt     = cth_pkg::xsh(mul_prod, cth_pkg::SH_FIN_2);
          mul_k_nxt     = cth_pkg::K_FIN_B;
          mul_start_nxt = 1'b1;
          state_nxt     = ST_SEED_B;
        end
      end
      ST_SEED_B: begin
        if (mul_done) begin
          mul_a_nxt     = cth_pkg::xsh(mul_prod, cth_pkg::SH_FIN_3) ^ extra_r;
          mul_k_nxt     = cth_pkg::K_GOLD;
          mul_start_nxt = 1'b1;
          state_nxt     = ST_SEED_G;
        end
      end
      ST_SEED_G: begin
        if (mul_done) begin
          acc_nxt  = mix_p;
          held_nxt = tok_r;
          hold_nxt = 1'b1;
          cnt_nxt  = CntW'(1);
          if (TOKENS_PER_BLK == 1) begin
            mul_a_nxt     = mix_p ^ {{(WW-TW){1'b0}}, tok_r};
            mul_k_nxt     = cth_pkg::K_GOLD;
            mul_start_nxt = 1'b1;
            state_nxt     = ST_TAIL_G;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PAIR_G: begin
        if (mul_done) begin
          acc_nxt = mix_p;
          if (cnt_r == CntLast) begin
            mul_a_nxt     = mix_p ^ LenWord;
            mul_k_nxt     = cth_pkg::K_GOLD;
            mul_start_nxt = 1'b1;
            state_nxt     = ST_LEN_G;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_TAIL_G: begin
        if (mul_done) begin
          mul_a_nxt     = mix_p ^ LenWord;
          mul_k_nxt     = cth_pkg::K_GOLD;
          mul_start_nxt = 1'b1;
          state_nxt     = ST_LEN_G;
        end
      end
      ST_LEN_G: begin
        if (mul_done) begin
          mul_a_nxt     = cth_pkg::xsh(mix_p, cth_pkg::SH_FIN_1);
          mul_k_nxt     = cth_pkg::K_FIN_A;
          mul_start_nxt = 1'b1;
          state_nxt     = ST_FIN_A;
        end
      end
      ST_FIN_A: begin
        if (mul_done) begin
          mul_a_nxt     = cth_pkg::xsh(mul_prod, cth_pkg::SH_FIN_2);
          mul_k_nxt     = cth_pkg::K_FIN_B;
          mul_start_nxt = 1'b1;
          state_nxt     = ST_FIN_B;
        end
      end
      ST_FIN_B: begin
        if (mul_done) begin
          acc_nxt   = cth_pkg::xsh(mul_prod, cth_pkg::SH_FIN_3);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait here only if the previous hash has not been taken yet
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = acc_r;
          parent_nxt    = acc_r;
          at_root_nxt   = 1'b0;
          cnt_nxt       = '0;
          hold_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      root_r      <= '0;
      at_root_r   <= 1'b1;
      cnt_r       <= '0;
      hold_r      <= 1'b0;
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      mul_k_r     <= cth_pkg::K_GOLD;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      at_root_r   <= at_root_nxt;
      cnt_r       <= cnt_nxt;
      hold_r      <= hold_nxt;
      mul_start_r <= mul_start_nxt;
      out_valid_r <= out_valid_nxt;
      mul_k_r     <= mul_k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hash_r <= out_hash_nxt;
    acc_r      <= acc_nxt;
    parent_r   <= parent_nxt;
    held_r     <= held_nxt;
    tok_r      <= tok_nxt;
    extra_r    <= extra_nxt;
    mul_a_r    <= mul_a_nxt;
  end

  a_done_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r != ST_IDLE && state_r != ST_EMIT))
    else $error("multiplier result arrived with no multiply pending");

  a_idle_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r < CntLast))
    else $error("token count reached block length while idle");

  a_idle_hold_parity: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (hold_r == cnt_r[0]))
    else $error("held token flag disagrees with token count");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && (!out_valid_r || out_ch.ready)) |=> out_valid_r)
    else $error("finished block hash not loaded into output register");

endmodule

>>> bench/chained_token_block_hash_core_test.sv
// testbench for the chained token block hash core: directed token table, then random token streams
module chained_token_block_hash_core_test;

  localparam int unsigned BLOCK_LEN   = 16;
  localparam int unsigned SETTLE      = 100;
  localparam int unsigned HOLD_OFF    = 800;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 84;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [63:0] K_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] K_FIN_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] K_FIN_B  = 64'h94d049bb133111eb;

  typedef struct packed {
    logic [31:0] tok;
    logic [63:0] salt;
    logic        rs;
  } tok_row_t;

  // hashes are too scrambled to type in, so every row goes through the predictor
  localparam int unsigned N_DIR = 22;
  tok_row_t dir_tab [N_DIR] = '{
    '{32'h0000_0000, 64'hffff_ffff_ffff_ffff, 1'b1},
    '{32'hffff_ffff, 64'h0123_4567_89ab_cdef, 1'b0},
    '{32'h0000_0000, 64'hffff_ffff_ffff_ffff, 1'b0},
    '{32'hffff_ffff, 64'h0000_0000_0000_0000, 1'b0},
    '{32'h8000_0000, 64'h8000_0000_0000_0000, 1'b0},
    '{32'h0000_0001, 64'h0000_0000_0000_0001, 1'b0},
    '{32'h7fff_ffff, 64'h5555_5555_5555_5555, 1'b0},
    '{32'hffff_fffe, 64'haaaa_aaaa_aaaa_aaaa, 1'b0},
    '{32'ha5a5_a5a5, 64'hdead_beef_cafe_f00d, 1'b0},
    '{32'h5a5a_5a5a, 64'h0000_0000_0000_0000, 1'b0},
    '{32'h1234_5678, 64'h1111_2222_3333_4444, 1'b0},
    '{32'h9abc_def0, 64'hffff_ffff_ffff_ffff, 1'b0},
    '{32'h0000_0000, 64'h7fff_ffff_ffff_ffff, 1'b0},
    '{32'hffff_ffff, 64'h0f0f_0f0f_0f0f_0f0f, 1'b0},
    '{32'h0f0f_0f0f, 64'hf0f0_f0f0_f0f0_f0f0, 1'b0},
    '{32'hf0f0_f0f0, 64'h0000_0000_ffff_ffff, 1'b0},
    // chained block with a zero salt
    '{32'h1111_1111, 64'h0000_0000_0000_0000, 1'b0},
    '{32'h2222_2222, 64'hdead_beef_dead_beef, 1'b0},
    '{32'h3333_3333, 64'hffff_ffff_ffff_ffff, 1'b0},
    // restart with a half pair held, then again after a full pair
    '{32'hffff_ffff, 64'h0000_0000_0000_0000, 1'b1},
    '{32'h0000_0000, 64'h1234_5678_9abc_def0, 1'b0},
    '{32'h0000_0000, 64'hffff_ffff_ffff_ffff, 1'b1}
  };

  logic clk = 1'b0;
  logic rst_n;

  cth_cfg_if cfg_ch();
  cth_in_if  in_ch();
  cth_out_if out_ch();

  chained_token_block_hash_core #(
    .TOKENS_PER_BLK(BLOCK_LEN)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // chain state mirrored from the block
  logic [63:0] seed_m;
  logic [63:0] parent_m;
  logic [63:0] mix_m;
  int unsigned count_m;
  logic [31:0] low_m;
  bit          pending_m;
  bit          from_root_m;

  logic [63:0] hash_q[$];
  int unsigned bad_count;
  bit          no_idle;
  bit          hold_req;

  function automatic logic [63:0] splitmix_fin(input logic [63:0] v);
    logic [63:0] x;
    x = v ^ (v >> 30);
    x = x * K_FIN_A;
    x = x ^ (x >> 27);
    x = x * K_FIN_B;
    return x ^ (x >> 31);
  endfunction

  function automatic logic [63:0] golden_absorb(input logic [63:0] s, input logic [63:0] w);
    logic [63:0] x;
    x = (s ^ w) * K_GOLDEN;
    return x ^ (x >> 29);
  endfunction

  function void predict_token(input logic [31:0] tok, input logic [63:0] salt, input bit rs);
    logic [63:0] h;
    if (rs) begin
      from_root_m = 1'b1;
      count_m     = 0;
      pending_m   = 1'b0;
      low_m       = '0;
    end
    if (count_m == 0) begin
      mix_m     = golden_absorb(splitmix_fin(from_root_m ? seed_m : parent_m), salt);
      pending_m = 1'b0;
    end
    if (pending_m) begin
      mix_m     = golden_absorb(mix_m, {tok, low_m});
      pending_m = 1'b0;
      low_m     = '0;
    end else begin
      low_m     = tok;
      pending_m = 1'b1;
    end
    count_m++;
    if (count_m >= BLOCK_LEN) begin
      // odd block length leaves a lone token, absorbed zero-extended
      if (pending_m) mix_m = golden_absorb(mix_m, {32'h0, low_m});
      h           = splitmix_fin(golden_absorb(mix_m, 64'(BLOCK_LEN)));
      parent_m    = h;
      from_root_m = 1'b0;
      mix_m       = h;
      count_m     = 0;
      pending_m   = 1'b0;
      low_m       = '0;
      hash_q.push_back(h);
    end
  endfunction

  function void check_hash(input logic [63:0] got);
    logic [63:0] want;
    if (hash_q.size() == 0) begin
      bad_count++;
      if (bad_count <= MAX_REPORTS) $display("unexpected block hash: expected none, got %h", got);
      return;
    end
    want = hash_q.pop_front();
    if (got !== want) begin
      bad_count++;
      if (bad_count <= MAX_REPORTS)
        $display("block hash mismatch: expected %h, got %h", want, got);
    end
  endfunction

  function automatic int unsigned pick_wait();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_token(input logic [31:0] tok, input logic [63:0] salt, input bit rs);
    int unsigned gap;
    gap = pick_wait();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.token   <= tok;
    in_ch.extra   <= salt;
    in_ch.restart <= rs;
    do @(posedge clk); while (!in_ch.ready);
    predict_token(tok, salt, rs);
  endtask

  task automatic send_random(input bit rs_force);
    logic [31:0] tok;
    logic [63:0] salt;
    bit          rs;
    case ($urandom_range(0, 7))
      0:       tok = '0;
      1:       tok = '1;
      default: tok = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0:       salt = '0;
      1:       salt = '1;
      default: salt = {$urandom, $urandom};
    endcase
    rs = rs_force || ($urandom_range(0, 63) == 0);
    send_token(tok, salt, rs);
  endtask

  task automatic write_seed(input logic [63:0] v);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.root_seed <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    seed_m = v;
  endtask

  // a partial block may still be absorbing after the last hash came out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [63:0] seeds [PHASES];
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.token      <= '0;
    in_ch.extra      <= '0;
    in_ch.restart    <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.root_seed <= '0;
    seed_m      = '0;
    parent_m    = '0;
    mix_m       = '0;
    count_m     = 0;
    low_m       = '0;
    pending_m   = 1'b0;
    from_root_m = 1'b1;
    bad_count   = 0;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    seeds[0] = 64'h0;
    seeds[1] = {$urandom, $urandom};
    seeds[2] = 64'hffff_ffff_ffff_ffff;
    seeds[3] = 64'h8000_0000_0000_0000;
    seeds[4] = {$urandom, $urandom};
    seeds[5] = 64'h1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_seed(64'hffff_ffff_ffff_ffff);
    for (int i = 0; i < N_DIR; i++) send_token(dir_tab[i].tok, dir_tab[i].salt, dir_tab[i].rs);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_seed(seeds[ph]);
      no_idle = (ph == 2 || ph == 3);
      // output stalls long enough for the block to back up into the token side
      if (ph == 2) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random(i == 0 && (ph % 2 == 1));
    end
    no_idle = 1'b0;

    in_ch.valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (bad_count == 0 && hash_q.size() == 0) begin
      $display("** chained_token_block_hash_core: PASSED **");
    end else begin
      $display("** chained_token_block_hash_core: FAILED **");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        stall    = HOLD_OFF;
        hold_req = 1'b0;
      end else begin
        stall = pick_wait();
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      check_hash(out_ch.digest);
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("** chained_token_block_hash_core: FAILED **");
    $finish;
  end

endmodule
